// ----- hdl/isse_pkg.sv -----
// ----------------------------------------------------------------------------
// isse_pkg
// shared types and constants for the integer set successor engine
// ----------------------------------------------------------------------------
package isse_pkg;

   localparam int unsigned KEY_BITS = 16;
   localparam int unsigned CMD_W  = 3;
   localparam int unsigned OUT_W  = 16;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned BIT_W  = 6;

   localparam logic [1:0] BOUND_LO = 2'd1;
   localparam logic [1:0] BOUND_HI = 2'd2;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_MEMBER = 3'd2,
      CMD_SUCC   = 3'd3,
      CMD_PRED   = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEAF,
      ST_MOD,
      ST_SUM,
      ST_TOP,
      ST_SUMRD,
      ST_LEAFRD,
      ST_BLO,
      ST_BHI,
      ST_DONE
   } state_type;

   // per-state control strobes and bound word select, issued by the controller
   typedef struct packed {
      logic       load;
      logic       leaf_check;
      logic       modify;
      logic       sum_check;
      logic       top_check;
      logic       sum_read;
      logic       leaf_read;
      logic [1:0] bound;
      logic       finish;
   } ctrl_type;

   typedef struct packed {
      logic       is_update;
      logic       is_query;
      logic       hit;
      logic       none;
   } stat_type;

   function automatic logic [5:0] lowest_bit(input logic [63:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) n = 6'(i);
      end
      return n;
   endfunction

   function automatic logic [5:0] highest_bit(input logic [63:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = 6'(i);
      end
      return n;
   endfunction

endpackage

// ----- hdl/integer_set_successor_engine.sv -----
// ----------------------------------------------------------------------------
// integer_set_successor_engine
// ordered integer set with insert, delete, member, successor and predecessor
// ----------------------------------------------------------------------------
// One command at a time. Insert and delete step through leaf read, check,
// write, both bound words read through the two leaf store read ports, bound
// update and result; member, an absent delete and unknown commands go from
// the leaf check straight to the result. Successor and predecessor end after
// the leaf check when the answer lies in the query word or none can exist;
// else they check the summary and top words, and end there when no neighbour
// exists beyond the query word, or read the summary and leaf words of the
// neighbour. The result is registered in the same cycle that req_tready
// rises again; a result held by rsp_tready stalls the engine. After reset the
// leaf store is cleared one word a cycle, during which req_tready stays low.
module integer_set_successor_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // command[2:0], key[18:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // found, neighbor, set_nonempty, set_min, set_max
);

   isse_pkg::ctrl_type ctrl;
   isse_pkg::stat_type stat;
   logic busy, clr_busy, start, out_free;
   logic        r_found, r_nonempty;
   logic [15:0] r_nb, r_min, r_max;
   logic        rsp_valid_ff;
   logic [49:0] rsp_data_ff;

   assign req_tready = !busy && !clr_busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   isse_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .out_free(out_free),
      .stat(stat), .busy(busy), .ctrl(ctrl)
   );

   isse_dp u_dp (
      .clock(clock), .reset(reset),
      .in_cmd(req_tdata[2:0]), .in_key(req_tdata[18:3]),
      .ctrl(ctrl), .stat(stat), .clr_busy(clr_busy),
      .res_found(r_found), .res_neighbor(r_nb), .res_nonempty(r_nonempty),
      .res_min(r_min), .res_max(r_max)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= {r_max, r_min, r_nonempty, r_nb, r_found};
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

// ----- hdl/isse_ctrl.sv -----
// ----------------------------------------------------------------------------
// isse_ctrl
// command sequencer for the bitmap search and update
// ----------------------------------------------------------------------------
module isse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                out_free,
   input  isse_pkg::stat_type  stat,
   output logic                busy,
   output isse_pkg::ctrl_type  ctrl
);

   isse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= isse_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isse_pkg::ST_IDLE:   if (start) state_in = isse_pkg::ST_LEAF;
         isse_pkg::ST_LEAF: begin
            if (stat.is_update)     state_in = isse_pkg::ST_MOD;
            else if (stat.is_query) state_in = isse_pkg::ST_SUM;
            else                    state_in = isse_pkg::ST_DONE;
         end
         isse_pkg::ST_MOD:    state_in = isse_pkg::ST_BLO;
         isse_pkg::ST_SUM: begin
            if (stat.hit)       state_in = isse_pkg::ST_DONE;
            else                state_in = isse_pkg::ST_TOP;
         end
         isse_pkg::ST_TOP: begin
            if (stat.none)      state_in = isse_pkg::ST_DONE;
            else                state_in = isse_pkg::ST_SUMRD;
         end
         isse_pkg::ST_SUMRD:  state_in = isse_pkg::ST_LEAFRD;
         isse_pkg::ST_LEAFRD: state_in = isse_pkg::ST_DONE;
         isse_pkg::ST_BLO:    state_in = isse_pkg::ST_BHI;
         isse_pkg::ST_BHI:    state_in = isse_pkg::ST_DONE;
         isse_pkg::ST_DONE:   if (out_free) state_in = isse_pkg::ST_IDLE;
         default:             state_in = isse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      case (state_ff)
         isse_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         isse_pkg::ST_LEAF:   ctrl.leaf_check = 1'b1;
         isse_pkg::ST_MOD:    ctrl.modify     = 1'b1;
         isse_pkg::ST_SUM:    ctrl.sum_check  = 1'b1;
         isse_pkg::ST_TOP:    ctrl.top_check  = 1'b1;
         isse_pkg::ST_SUMRD:  ctrl.sum_read   = 1'b1;
         isse_pkg::ST_LEAFRD: ctrl.leaf_read  = 1'b1;
         isse_pkg::ST_BLO:    ctrl.bound      = isse_pkg::BOUND_LO;
         isse_pkg::ST_BHI:    ctrl.bound      = isse_pkg::BOUND_HI;
         isse_pkg::ST_DONE:   ctrl.finish     = out_free;
         default:             ctrl = '0;
      endcase
   end

endmodule

// ----- hdl/isse_dp.sv -----
// ----------------------------------------------------------------------------
// isse_dp
// three-level bitmap store with search and update datapath
// ----------------------------------------------------------------------------
module isse_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            in_cmd,
   input  logic [15:0]           in_key,
   input  isse_pkg::ctrl_type    ctrl,
   output isse_pkg::stat_type    stat,
   output logic                  clr_busy,
   output logic                  res_found,
   output logic [15:0]           res_neighbor,
   output logic                  res_nonempty,
   output logic [15:0]           res_min,
   output logic [15:0]           res_max
);

   localparam int unsigned KEY_BITS   = isse_pkg::KEY_BITS;
   localparam int unsigned LW_BITS = (KEY_BITS > 6) ? KEY_BITS - 6 : 1;
   localparam int unsigned LEAF_WORDS = (KEY_BITS > 6) ? (1 << (KEY_BITS - 6)) : 1;
   localparam int unsigned SUM_WORDS  = (LEAF_WORDS + 63) / 64;
   localparam int unsigned SW_BITS = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam logic [KEY_BITS-1:0] KEY_TOP = '1;

   logic [63:0]   leaf_mem [LEAF_WORDS];
   logic [63:0]   sum_ff   [SUM_WORDS];
   logic [SUM_WORDS-1:0] top_ff;

   logic [KEY_BITS-1:0] key_ff, qkey_ff, min_ff, max_ff, nb_ff;
   logic [2:0]   cmd_ff;
   logic         found_ff, nonempty_ff, present_ff, none_ff;
   logic [63:0]  leaf_rd_ff, bword_ff;
   logic [LW_BITS-1:0] rd_addr, clr_addr_ff;
   logic         clr_ff;
   logic [SW_BITS-1:0] s_sel_ff;
   logic         hit_ff;

   // qkey and key split
   logic [LW_BITS-1:0] qw, kw;
   logic [5:0]  qb, kb;
   logic [SW_BITS-1:0] qs, ks;
   logic [5:0]  qwl, kwl;

   assign qw  = LW_BITS'(qkey_ff >> 6);
   assign kw  = LW_BITS'(key_ff >> 6);
   assign qb  = 6'(qkey_ff);
   assign kb  = 6'(key_ff);
   assign qs  = SW_BITS'(qw >> 6);
   assign ks  = SW_BITS'(kw >> 6);
   assign qwl = 6'(qw);
   assign kwl = 6'(kw);

   logic is_pred;
   assign is_pred = (cmd_ff == isse_pkg::CMD_PRED);

   logic [63:0] m_from_b, m_upto_b, m_sum_above, m_sum_below;
   assign m_from_b    = ~64'd0 << qb;
   assign m_upto_b    = ~64'd0 >> (6'd63 - qb);
   assign m_sum_above = (qwl == 6'd63) ? 64'd0 : (~64'd0 << (qwl + 6'd1));
   assign m_sum_below = (qwl == 6'd0) ? 64'd0 : (~64'd0 >> (7'd64 - {1'b0, qwl}));

   logic [63:0] sum_word, sum_masked, top_masked;
   logic [63:0] top64;
   assign sum_word   = sum_ff[qs];
   assign sum_masked = sum_word & (is_pred ? m_sum_below : m_sum_above);
   assign top64      = 64'(top_ff);

   always_comb begin
      top_masked = '0;
      for (int i = 0; i < 64; i++) begin
         if (i < int'(SUM_WORDS)) begin
            if (is_pred) top_masked[i] = top64[i] && (SW_BITS'(i) < qs);
            else         top_masked[i] = top64[i] && (SW_BITS'(i) > qs);
         end
      end
   end

   logic [KEY_BITS-1:0] in_kk, in_qk;
   assign in_kk = KEY_BITS'(in_key);

   always_comb begin
      in_qk = in_kk;
      if (in_cmd == isse_pkg::CMD_SUCC)      in_qk = in_kk + 1'b1;
      else if (in_cmd == isse_pkg::CMD_PRED) in_qk = in_kk - 1'b1;
   end

   // bound words: first and last non-empty leaf word
   logic [SW_BITS-1:0] top_lo, top_hi;
   assign top_lo = SW_BITS'(isse_pkg::lowest_bit(top64));
   assign top_hi = SW_BITS'(isse_pkg::highest_bit(top64));

   logic [LW_BITS-1:0] blo_w, bhi_w;
   assign blo_w = LW_BITS'({top_lo, isse_pkg::lowest_bit(sum_ff[top_lo])});
   assign bhi_w = LW_BITS'({top_hi, isse_pkg::highest_bit(sum_ff[top_hi])});

   // target leaf word reached through the top level
   logic [LW_BITS-1:0] w_tgt_ff, w_far;
   assign w_far = LW_BITS'({s_sel_ff, is_pred ? isse_pkg::highest_bit(sum_ff[s_sel_ff])
                                              : isse_pkg::lowest_bit(sum_ff[s_sel_ff])});

   // leaf read address: query word, search target word or lower bound word
   always_comb begin
      rd_addr = qw;
      if (ctrl.load)                             rd_addr = LW_BITS'(in_qk >> 6);
      else if (ctrl.sum_read)                    rd_addr = hit_ff ? w_tgt_ff : w_far;
      else if (ctrl.bound == isse_pkg::BOUND_LO) rd_addr = blo_w;
   end

   assign clr_busy = clr_ff;

   always_ff @(posedge clock) begin
      if (clr_ff) leaf_mem[clr_addr_ff] <= '0;
      else if (ctrl.modify && (cmd_ff == isse_pkg::CMD_INSERT || present_ff))
         leaf_mem[kw] <= (cmd_ff == isse_pkg::CMD_INSERT) ?
                         (leaf_rd_ff | (64'd1 << kb)) : (leaf_rd_ff & ~(64'd1 << kb));
      leaf_rd_ff <= leaf_mem[rd_addr];
      bword_ff   <= leaf_mem[bhi_w];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LW_BITS'(LEAF_WORDS - 1)) clr_ff <= 1'b0;
      end
   end

   logic [63:0] leaf_new;
   assign leaf_new = (cmd_ff == isse_pkg::CMD_INSERT) ?
                     (leaf_rd_ff | (64'd1 << kb)) : (leaf_rd_ff & ~(64'd1 << kb));

   logic [63:0] sum_new;
   always_comb begin
      sum_new = sum_ff[ks];
      if (cmd_ff == isse_pkg::CMD_INSERT) sum_new[kwl] = 1'b1;
      else if (leaf_new == 64'd0)         sum_new[kwl] = 1'b0;
   end

   logic [63:0] leaf_qmask;
   assign leaf_qmask = leaf_rd_ff & (is_pred ? m_upto_b : m_from_b);

   logic [5:0] lo_leaf, hi_leaf;
   assign lo_leaf = isse_pkg::lowest_bit(leaf_rd_ff);
   assign hi_leaf = isse_pkg::highest_bit(leaf_rd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(SUM_WORDS); i++) sum_ff[i] <= '0;
         top_ff      <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
         nonempty_ff <= 1'b0;
         found_ff    <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         if (ctrl.load) begin
            cmd_ff   <= in_cmd;
            key_ff   <= in_kk;
            qkey_ff  <= in_qk;
            found_ff <= 1'b0;
            nb_ff    <= '0;
            hit_ff   <= 1'b0;
            none_ff  <= ((in_cmd == isse_pkg::CMD_SUCC) && (in_kk == KEY_TOP)) ||
                        ((in_cmd == isse_pkg::CMD_PRED) && (in_kk == '0));
         end
         if (ctrl.leaf_check) begin
            present_ff <= leaf_rd_ff[kb];
            if (cmd_ff == isse_pkg::CMD_DELETE || cmd_ff == isse_pkg::CMD_MEMBER)
               found_ff <= leaf_rd_ff[kb];
            if (cmd_ff == isse_pkg::CMD_INSERT) found_ff <= 1'b1;
            if ((cmd_ff == isse_pkg::CMD_SUCC || cmd_ff == isse_pkg::CMD_PRED)
                && !none_ff && leaf_qmask != 64'd0) begin
               found_ff <= 1'b1;
               hit_ff   <= 1'b1;
               nb_ff    <= {qw, is_pred ? isse_pkg::highest_bit(leaf_qmask)
                                        : isse_pkg::lowest_bit(leaf_qmask)};
            end
         end
         if (ctrl.sum_check) begin
            if (!hit_ff && !none_ff && sum_masked != 64'd0) begin
               w_tgt_ff <= LW_BITS'({qs, is_pred ? isse_pkg::highest_bit(sum_masked)
                                                 : isse_pkg::lowest_bit(sum_masked)});
               hit_ff   <= 1'b1;
               s_sel_ff <= qs;
            end
         end
         if (ctrl.top_check) begin
            if (hit_ff && !found_ff) begin
               // summary hit already, move on to leaf read
            end else if (!hit_ff) begin
               if (none_ff || top_masked == 64'd0) begin
                  none_ff <= 1'b1;
               end else begin
                  s_sel_ff <= is_pred ? SW_BITS'(isse_pkg::highest_bit(top_masked))
                                      : SW_BITS'(isse_pkg::lowest_bit(top_masked));
               end
            end
         end
         if (ctrl.sum_read && !hit_ff) begin
            w_tgt_ff <= w_far;
         end
         if (ctrl.leaf_read) begin
            found_ff <= 1'b1;
            nb_ff    <= {w_tgt_ff, is_pred ? hi_leaf : lo_leaf};
         end
         if (ctrl.modify && (cmd_ff == isse_pkg::CMD_INSERT || present_ff)) begin
            sum_ff[ks] <= sum_new;
            top_ff[ks] <= (sum_new != 64'd0);
         end
         if (ctrl.bound == isse_pkg::BOUND_LO) begin
            nonempty_ff <= (top_ff != '0);
         end
         // both bound words were read at the previous edge
         if (ctrl.bound == isse_pkg::BOUND_HI) begin
            if (top_ff != '0) begin
               min_ff <= KEY_BITS'({blo_w, lo_leaf});
               max_ff <= KEY_BITS'({bhi_w, isse_pkg::highest_bit(bword_ff)});
            end else begin
               min_ff <= '0;
               max_ff <= '0;
            end
         end
      end
   end

   assign stat.is_update = (cmd_ff == isse_pkg::CMD_INSERT) ||
                           (cmd_ff == isse_pkg::CMD_DELETE && leaf_rd_ff[kb]);
   assign stat.is_query  = (cmd_ff == isse_pkg::CMD_SUCC || cmd_ff == isse_pkg::CMD_PRED)
                           && !none_ff && leaf_qmask == 64'd0;
   assign stat.hit       = hit_ff && found_ff;
   assign stat.none      = none_ff || (!hit_ff && top_masked == 64'd0);

   assign res_found    = found_ff;
   assign res_neighbor = found_ff ? 16'(nb_ff) : 16'd0;
   assign res_nonempty = nonempty_ff;
   assign res_min      = 16'(min_ff);
   assign res_max      = 16'(max_ff);

`ifndef NO_ASSERTIONS
   a_nb_zero: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> res_neighbor == 16'd0) else $error("neighbor without hit");
   a_empty_bounds: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish && !nonempty_ff |-> min_ff == '0 && max_ff == '0)
      else $error("bounds set on empty set");
   a_no_mod_clr: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !ctrl.modify) else $error("update during clear");
`endif

endmodule

// ----- bench/integer_set_successor_checker.sv -----
// ----------------------------------------------------------------------------
// integer_set_successor_checker
// watches both channels, predicts each result from its own copy of the key
// set and compares it field by field with what the engine returns
// ----------------------------------------------------------------------------
module integer_set_successor_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // command[2:0], key[18:3]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // found, neighbor, set_nonempty, set_min, set_max
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // lowest field last, matching the result transfer layout
   typedef struct packed {
      logic [15:0] high_key;
      logic [15:0] low_key;
      logic        nonempty;
      logic [15:0] neighbor;
      logic        found;
   } answer_type;

   logic [63:0] key_words [1024];
   answer_type  answers_due [$];

   function automatic logic lowest_key_from(input int k, output logic [15:0] res);
      for (int j = k; j < 65536; j++) begin
         if (key_words[j >> 6] == '0) begin
            j = ((j >> 6) << 6) + 63;
         end else if (key_words[j >> 6][j & 63]) begin
            res = 16'(j);
            return 1'b1;
         end
      end
      res = '0;
      return 1'b0;
   endfunction

   function automatic logic highest_key_upto(input int k, output logic [15:0] res);
      for (int j = k; j >= 0; j--) begin
         if (key_words[j >> 6] == '0) begin
            j = (j >> 6) << 6;
         end else if (key_words[j >> 6][j & 63]) begin
            res = 16'(j);
            return 1'b1;
         end
      end
      res = '0;
      return 1'b0;
   endfunction

   function automatic answer_type apply_command(input logic [2:0] cmd, input logic [15:0] k);
      answer_type  a;
      logic        present;
      logic [15:0] lo, hi;
      a = '0;
      present = key_words[k[15:6]][k[5:0]];
      case (cmd)
         isse_pkg::CMD_INSERT: begin
            key_words[k[15:6]][k[5:0]] = 1'b1;
            a.found = 1'b1;
         end
         isse_pkg::CMD_DELETE: begin
            a.found = present;
            key_words[k[15:6]][k[5:0]] = 1'b0;
         end
         isse_pkg::CMD_MEMBER: a.found = present;
         isse_pkg::CMD_SUCC:
            if (k != 16'hffff) a.found = lowest_key_from(int'(k) + 1, a.neighbor);
         isse_pkg::CMD_PRED:
            if (k != 16'h0000) a.found = highest_key_upto(int'(k) - 1, a.neighbor);
         default: ;
      endcase
      if (!a.found) a.neighbor = '0;
      a.nonempty = lowest_key_from(0, lo);
      void'(highest_key_upto(65535, hi));
      a.low_key  = a.nonempty ? lo : '0;
      a.high_key = a.nonempty ? hi : '0;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      int errs;
      errs = error_count;
      if (reset) begin
         foreach (key_words[i]) key_words[i] = '0;
         answers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[49:0];
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result transfer, actual %h", $time, got);
               errs++;
            end else begin
               want = answers_due.pop_front();
               if (want.found !== got.found) begin
                  $display("%0t: found expected %b actual %b", $time, want.found, got.found);
                  errs++;
               end
               if (want.neighbor !== got.neighbor) begin
                  $display("%0t: neighbor expected %h actual %h",
                           $time, want.neighbor, got.neighbor);
                  errs++;
               end
               if (want.nonempty !== got.nonempty) begin
                  $display("%0t: set_nonempty expected %b actual %b",
                           $time, want.nonempty, got.nonempty);
                  errs++;
               end
               if (want.low_key !== got.low_key) begin
                  $display("%0t: set_min expected %h actual %h",
                           $time, want.low_key, got.low_key);
                  errs++;
               end
               if (want.high_key !== got.high_key) begin
                  $display("%0t: set_max expected %h actual %h",
                           $time, want.high_key, got.high_key);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(apply_command(req_tdata[2:0], req_tdata[18:3]));
      end
      error_count   <= errs;
      pending_count <= answers_due.size();
   end

endmodule

// ----- bench/integer_set_successor_engine_tb.sv -----
// ----------------------------------------------------------------------------
// integer_set_successor_engine_tb
// drives insert, delete, member, successor and predecessor commands into the
// engine under random stalls on both channels; the checker scores results
// ----------------------------------------------------------------------------
module integer_set_successor_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   int          error_count, pending_count;
   int          phase      = 0;
   logic        hold_off   = 1'b0;

   always #4 clock = ~clock;

   integer_set_successor_engine dut (.*);
   integer_set_successor_checker scoreboard (.*);

   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver side, with one long hold-off on request
   initial begin
      int pct;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         pct = (phase == 0) ? 59 : (phase == 1) ? 33 : 0;
         rsp_tready <= ($urandom_range(99) >= pct);
      end
   end

   task automatic send(input logic [2:0] cmd, input logic [15:0] k);
      int pct;
      pct = (phase == 0) ? 33 : (phase == 1) ? 59 : 0;
      while ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, k, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [15:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 16'(($urandom_range(7) << 13) | $urandom_range(300));
      if (r < 85) return 16'($urandom_range(65535));
      if (r < 93) return 16'($urandom_range(70));
      return 16'(65535 - $urandom_range(70));
   endfunction

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(99);
      if (r < 30) return isse_pkg::CMD_INSERT;
      if (r < 55) return isse_pkg::CMD_DELETE;
      if (r < 65) return isse_pkg::CMD_MEMBER;
      if (r < 80) return isse_pkg::CMD_SUCC;
      if (r < 95) return isse_pkg::CMD_PRED;
      return 3'($urandom_range(5, 7));
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // empty set, extremes, duplicates, absent delete, unknown commands
      send(isse_pkg::CMD_SUCC, 16'h0000);
      send(isse_pkg::CMD_PRED, 16'hffff);
      send(isse_pkg::CMD_DELETE, 16'h1234);
      send(isse_pkg::CMD_INSERT, 16'hffff);
      send(isse_pkg::CMD_INSERT, 16'h0000);
      send(isse_pkg::CMD_INSERT, 16'h0000);
      send(isse_pkg::CMD_SUCC, 16'hffff);
      send(isse_pkg::CMD_PRED, 16'h0000);
      send(isse_pkg::CMD_SUCC, 16'h0000);
      send(isse_pkg::CMD_PRED, 16'hffff);
      send(isse_pkg::CMD_INSERT, 16'h8040);
      send(isse_pkg::CMD_SUCC, 16'h0001);
      send(isse_pkg::CMD_PRED, 16'hfffe);
      send(isse_pkg::CMD_MEMBER, 16'h8040);
      send(isse_pkg::CMD_MEMBER, 16'h8041);
      send(3'd5, 16'h8040);
      send(3'd6, 16'h0000);
      send(3'd7, 16'hffff);
      send(isse_pkg::CMD_DELETE, 16'h0000);
      send(isse_pkg::CMD_DELETE, 16'hffff);
      send(isse_pkg::CMD_DELETE, 16'h8040);
      send(isse_pkg::CMD_DELETE, 16'h8040);
      send(isse_pkg::CMD_MEMBER, 16'h5555);
      send(isse_pkg::CMD_MEMBER, 16'haaaa);
      for (int i = 0; i < 1950; i++) begin
         phase = (i < 650) ? 0 : (i < 1300) ? 1 : 2;
         if (i == 300) hold_off = 1'b1;
         if (i == 1000) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         send(pick_command(), pick_key());
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
